// ===== rtl/bfe_pkg.sv =====
// Shared types, codes and defaults for the benchmark fitness evaluator.
`timescale 1ns / 1ps

package bfe_pkg;

    // Default configuration
    localparam int MAX_GENES_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 12;

    // Test function codes held in the configuration register
    typedef enum logic [1:0] {
        FN_SUM      = 2'd0,
        FN_DIXON    = 2'd1,
        FN_ZAKHAROV = 2'd2,
        FN_TRID     = 2'd3
    } t_func;

    // Input transaction: one gene
    typedef struct packed {
        logic signed [15:0] gene;
        logic               last;
    } t_in_item;

    // Output transaction: one fitness value
    typedef struct packed {
        logic signed [63:0] fitness;
        logic               saturated;
    } t_out_item;

    // Rounding applied to a product: none, fraction bits, fraction bits plus two
    typedef enum logic [1:0] {
        RND_NONE  = 2'd0,
        RND_FRAC  = 2'd1,
        RND_FRAC2 = 2'd2
    } t_rnd;

    // Operation currently worked on by the sequencer
    typedef enum logic [3:0] {
        OP_SUM      = 4'd0,
        OP_DP_FIRST = 4'd1,
        OP_DP_SQ    = 4'd2,
        OP_DP_DQ    = 4'd3,
        OP_DP_W     = 4'd4,
        OP_Z_SQ     = 4'd5,
        OP_Z_S      = 4'd6,
        OP_T_SQ     = 4'd7,
        OP_T_PR     = 4'd8,
        OP_Z_S2     = 4'd9,
        OP_Z_S4     = 4'd10
    } t_op;

    // Addend source of the saturating accumulator
    typedef enum logic [1:0] {
        SRC_GENE = 2'd0,
        SRC_MUL  = 2'd1,
        SRC_TRID = 2'd2
    } t_src;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_ISSUE  = 3'd1,
        ST_WAIT   = 3'd2,
        ST_POST   = 3'd3,
        ST_GEND   = 3'd4,
        ST_TFIN   = 3'd5,
        ST_FINISH = 3'd6
    } t_state;

    // Sequencer to datapath controls
    typedef struct packed {
        logic mul_start;
        t_op  op;
        logic acc_en;
        logic acc_second;
        t_src acc_src;
        logic dq_en;
        logic mul_post;
        logic gene_end;
        logic trid_fin;
        logic finish;
    } t_ctl;

    // Datapath to sequencer status
    typedef struct packed {
        logic idx_zero;
        logic last;
        logic mul_done;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/bfe_mul.sv =====
// Shared multiplier: signed 64x64 product from four 32x32 partial products, rounded and clamped.
`timescale 1ns / 1ps

module bfe_mul
    import bfe_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  t_rnd               i_mode,
    output logic               o_done,
    output logic signed [63:0] o_res,
    output logic               o_sat
);

    localparam int PW = 130;
    localparam logic signed [PW-1:0] HALF_F  =
        {{(PW-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);
    localparam logic signed [PW-1:0] HALF_F2 =
        {{(PW-1){1'b0}}, 1'b1} << (FRACTION_BITS + 1);

    logic                 r_busy;
    logic [2:0]           r_cnt;
    logic                 r_done;
    logic [63:0]          r_ma;
    logic [63:0]          r_mb;
    logic                 r_neg;
    t_rnd                 r_mode;
    logic [63:0]          r_pp;
    logic [127:0]         r_acc;
    logic signed [PW-1:0] r_w;
    logic signed [63:0]   r_res;
    logic                 r_sat;

    logic [63:0]          w_ma;
    logic [63:0]          w_mb;
    logic [31:0]          w_asel;
    logic [31:0]          w_bsel;
    logic [63:0]          w_pp;
    logic [127:0]         w_pp_ext;
    logic signed [PW-1:0] w_half;
    logic signed [PW-1:0] w_mag;
    logic signed [PW-1:0] w_w;
    logic signed [PW-1:0] w_r;
    logic                 w_ovf;
    logic signed [63:0]   w_clamp;

    // Take operand magnitudes
    always_comb begin
        w_ma = i_a[63] ? (~64'(i_a) + 64'd1) : 64'(i_a);
        w_mb = i_b[63] ? (~64'(i_b) + 64'd1) : 64'(i_b);
    end

    // Pick the halves for partial product r_cnt: low/low, low/high, high/low, high/high
    always_comb begin
        w_asel = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        w_bsel = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        w_pp   = w_asel * w_bsel;
    end

    // Align the registered partial product of the previous step
    always_comb begin
        case (r_cnt)
            3'd1:       w_pp_ext = {64'd0, r_pp};
            3'd2, 3'd3: w_pp_ext = {32'd0, r_pp, 32'd0};
            default:    w_pp_ext = {r_pp, 64'd0};
        endcase
    end

    // Apply the sign and the rounding offset
    always_comb begin
        case (r_mode)
            RND_FRAC:  w_half = HALF_F;
            RND_FRAC2: w_half = HALF_F2;
            default:   w_half = '0;
        endcase
        w_mag = $signed({2'b00, r_acc});
        w_w   = r_neg ? (w_half - w_mag) : (w_half + w_mag);
    end

    // Shift out the fraction and clamp to 64 bits
    always_comb begin
        case (r_mode)
            RND_FRAC:  w_r = r_w >>> FRACTION_BITS;
            RND_FRAC2: w_r = r_w >>> (FRACTION_BITS + 2);
            default:   w_r = r_w;
        endcase
        w_ovf = (w_r[PW-1:63] != {(PW-63){w_r[PW-1]}});
        if (!w_ovf) begin
            w_clamp = w_r[63:0];
        end else if (w_r[PW-1]) begin
            w_clamp = {1'b1, 63'd0};
        end else begin
            w_clamp = {1'b0, {63{1'b1}}};
        end
    end

    // Step through partial products, rounding and clamping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ma   <= w_ma;
                r_mb   <= w_mb;
                r_neg  <= i_a[63] ^ i_b[63];
                r_mode <= i_mode;
                r_acc  <= '0;
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt <= 3'd3) begin
                    r_pp <= w_pp;
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + w_pp_ext;
                end
                if (r_cnt == 3'd5) begin
                    r_w <= w_w;
                end
                if (r_cnt == 3'd6) begin
                    r_res  <= w_clamp;
                    r_sat  <= w_ovf;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_sat  = r_sat;

endmodule

// ===== rtl/bfe_seq.sv =====
// Sequencer: walks each gene and the final combine through multiplier and adder.
`timescale 1ns / 1ps

module bfe_seq
    import bfe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_func i_func,
    input  t_stat i_stat,
    output t_ctl  o_ctl,
    output logic  o_in_ready
);

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;

    // Hold state and current operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_SUM;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // Advance through the operations of the selected function
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        o_ctl      = '0;
        o_ctl.op   = r_op;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_start) begin
                    case (i_func)
                        FN_SUM: begin
                            n_op    = OP_SUM;
                            n_state = ST_POST;
                        end
                        FN_DIXON: begin
                            n_op    = i_stat.idx_zero ? OP_DP_FIRST : OP_DP_SQ;
                            n_state = ST_ISSUE;
                        end
                        FN_ZAKHAROV: begin
                            n_op    = OP_Z_SQ;
                            n_state = ST_ISSUE;
                        end
                        default: begin
                            n_op    = OP_T_SQ;
                            n_state = ST_ISSUE;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                o_ctl.mul_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                o_ctl.mul_post = (r_op != OP_SUM);
                case (r_op)
                    OP_SUM: begin
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_GENE;
                        n_state       = ST_GEND;
                    end
                    OP_DP_SQ: begin
                        o_ctl.dq_en = 1'b1;
                        n_op        = OP_DP_DQ;
                        n_state     = ST_ISSUE;
                    end
                    OP_DP_DQ: begin
                        n_op    = OP_DP_W;
                        n_state = ST_ISSUE;
                    end
                    OP_Z_S, OP_T_PR: begin
                        o_ctl.acc_en     = 1'b1;
                        o_ctl.acc_second = 1'b1;
                        o_ctl.acc_src    = SRC_MUL;
                        n_state          = ST_GEND;
                    end
                    OP_Z_SQ: begin
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_MUL;
                        n_op          = OP_Z_S;
                        n_state       = ST_ISSUE;
                    end
                    OP_T_SQ: begin
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_MUL;
                        if (i_stat.idx_zero) begin
                            n_state = ST_GEND;
                        end else begin
                            n_op    = OP_T_PR;
                            n_state = ST_ISSUE;
                        end
                    end
                    OP_Z_S2: begin
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_MUL;
                        n_op          = OP_Z_S4;
                        n_state       = ST_ISSUE;
                    end
                    OP_Z_S4: begin
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_MUL;
                        n_state       = ST_FINISH;
                    end
                    default: begin
                        // Dixon-Price first gene and weighted term
                        o_ctl.acc_en  = 1'b1;
                        o_ctl.acc_src = SRC_MUL;
                        n_state       = ST_GEND;
                    end
                endcase
            end
            ST_GEND: begin
                o_ctl.gene_end = 1'b1;
                if (i_stat.last) begin
                    case (i_func)
                        FN_ZAKHAROV: begin
                            n_op    = OP_Z_S2;
                            n_state = ST_ISSUE;
                        end
                        FN_TRID: n_state = ST_TFIN;
                        default: n_state = ST_FINISH;
                    endcase
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_TFIN: begin
                o_ctl.acc_en   = 1'b1;
                o_ctl.acc_src  = SRC_TRID;
                o_ctl.trid_fin = 1'b1;
                n_state        = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/benchmark_fitness_evaluator_core.sv =====
// Benchmark fitness evaluator top level: candidate state, accumulators and output register.
// Each multiply pass runs on the shared 64x64 multiplier (four partial products, round, clamp);
// the plain sum takes no pass. A gene after the first takes three passes for Dixon-Price and
// two for Zakharov and Trid; a first gene takes one for Dixon-Price and Trid, two for
// Zakharov. At the last gene Zakharov adds two passes and Trid one combine step; the result
// then moves to the output register.
// Throughput: one gene at a time. Reset clears the function select and the candidate state.
`timescale 1ns / 1ps

module benchmark_fitness_evaluator_core
    import bfe_pkg::*;
#(
    parameter int MAX_GENES     = MAX_GENES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data
);

    localparam logic [6:0]         LAST_IDX = 7'(MAX_GENES - 1);
    localparam logic signed [63:0] ONE      = 64'sd1 <<< FRACTION_BITS;
    localparam logic signed [63:0] MIN64    = {1'b1, 63'd0};
    localparam logic signed [63:0] MAX64    = {1'b0, {63{1'b1}}};
    localparam int                 DQ_W     = (FRACTION_BITS > 15) ? FRACTION_BITS + 18 : 34;
    localparam logic signed [DQ_W-1:0] DQ_HALF =
        {{(DQ_W-1){1'b0}}, 1'b1} << (FRACTION_BITS - 1);

    t_func              r_func;
    logic [6:0]         r_idx;
    logic signed [15:0] r_prev;
    logic signed [63:0] r_first;
    logic signed [63:0] r_second;
    logic               r_ovf;
    logic signed [15:0] r_gene;
    logic               r_last;
    logic signed [63:0] r_dq;
    logic               r_out_valid;
    t_out_item          r_out;

    t_ctl               w_ctl;
    t_stat              w_stat;
    logic               w_accept;
    logic               w_mul_done;
    logic signed [63:0] w_mres;
    logic               w_msat;
    logic signed [63:0] w_gene;
    logic signed [63:0] w_gm1;
    logic signed [63:0] w_weight;
    logic signed [63:0] w_ma;
    logic signed [63:0] w_mb;
    t_rnd               w_mode;
    logic signed [63:0] w_acc_a;
    logic signed [63:0] w_acc_b;
    logic               w_acc_cin;
    logic signed [64:0] w_sum;
    logic               w_add_ovf;
    logic signed [63:0] w_add_res;
    logic signed [DQ_W-1:0] w_dsq;
    logic signed [DQ_W-1:0] w_dprev;
    logic signed [DQ_W-1:0] w_dq;

    assign w_accept = i_in_valid && o_in_ready;

    // Status toward the sequencer
    always_comb begin
        w_stat.idx_zero = (r_idx == '0);
        w_stat.last     = r_last;
        w_stat.mul_done = w_mul_done;
        w_stat.out_free = !r_out_valid || i_out_ready;
    end

    bfe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_func     (r_func),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl),
        .o_in_ready (o_in_ready)
    );

    // Select multiplier operands for the current operation
    always_comb begin
        w_gene   = 64'(r_gene);
        w_gm1    = w_gene - ONE;
        w_weight = 64'(r_idx) + 64'sd1;
        w_ma     = w_gene;
        w_mb     = w_gene;
        w_mode   = RND_NONE;
        case (w_ctl.op)
            OP_DP_FIRST, OP_T_SQ: begin
                w_ma   = w_gm1;
                w_mb   = w_gm1;
                w_mode = RND_FRAC;
            end
            OP_Z_SQ: w_mode = RND_FRAC;
            OP_DP_DQ: begin
                w_ma   = r_dq;
                w_mb   = r_dq;
                w_mode = RND_FRAC;
            end
            OP_DP_W: begin
                w_ma = w_mres;
                w_mb = w_weight;
            end
            OP_Z_S: w_ma = w_weight;
            OP_T_PR: begin
                w_mb   = 64'(r_prev);
                w_mode = RND_FRAC;
            end
            OP_Z_S2: begin
                w_ma   = r_second;
                w_mb   = r_second;
                w_mode = RND_FRAC2;
            end
            OP_Z_S4: begin
                w_ma   = w_mres;
                w_mb   = w_mres;
                w_mode = RND_FRAC;
            end
            default: w_mode = RND_NONE;
        endcase
    end

    bfe_mul #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .i_mode  (w_mode),
        .o_done  (w_mul_done),
        .o_res   (w_mres),
        .o_sat   (w_msat)
    );

    // Saturating accumulator add; Trid negation folds into inverted operand plus carry
    always_comb begin
        w_acc_a   = w_ctl.acc_second ? r_second : r_first;
        w_acc_cin = 1'b0;
        case (w_ctl.acc_src)
            SRC_GENE: w_acc_b = w_gene;
            SRC_TRID: begin
                w_acc_b   = ~r_second;
                w_acc_cin = (r_second != MIN64);
            end
            default:  w_acc_b = w_mres;
        endcase
        w_sum     = {w_acc_a[63], w_acc_a} + {w_acc_b[63], w_acc_b} + 65'(w_acc_cin);
        w_add_ovf = (w_sum[64] != w_sum[63]);
        if (!w_add_ovf) begin
            w_add_res = w_sum[63:0];
        end else if (w_sum[64]) begin
            w_add_res = MIN64;
        end else begin
            w_add_res = MAX64;
        end
    end

    // Dixon-Price inner term: round(2*x^2 - x_prev) from the exact square
    always_comb begin
        w_dsq   = DQ_W'($signed({1'b0, w_mres[31:0]})) <<< 1;
        w_dprev = DQ_W'(r_prev) <<< FRACTION_BITS;
        w_dq    = (w_dsq - w_dprev + DQ_HALF) >>> FRACTION_BITS;
    end

    // Candidate state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func   <= FN_SUM;
            r_idx    <= '0;
            r_prev   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_ovf    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_func   <= t_func'(i_cfg_wr_data);
            r_idx    <= '0;
            r_prev   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_ovf    <= 1'b0;
        end else if (w_ctl.finish) begin
            r_idx    <= '0;
            r_prev   <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (w_ctl.acc_en) begin
                if (w_ctl.acc_second) begin
                    r_second <= w_add_res;
                end else begin
                    r_first <= w_add_res;
                end
            end
            if ((w_ctl.acc_en && w_add_ovf) || (w_ctl.mul_post && w_msat)
                    || (w_ctl.trid_fin && r_second == MIN64)) begin
                r_ovf <= 1'b1;
            end
            if (w_ctl.gene_end) begin
                r_prev <= r_gene;
                r_idx  <= r_idx + 7'd1;
            end
        end
    end

    // Latch the gene being worked on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_gene <= i_in_data.gene;
            r_last <= i_in_data.last || (r_idx >= LAST_IDX);
        end
        if (w_ctl.dq_en) begin
            r_dq <= 64'(w_dq);
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.finish) begin
            r_out.fitness   <= r_first;
            r_out.saturated <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/bfe_checker.sv =====
// Port-level checks for the benchmark fitness evaluator, bound to the top level.
`timescale 1ns / 1ps

module bfe_checker
    import bfe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input t_out_item  o_out_data
);

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Drop ready for the cycle after an input transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready held after input transaction");

    // Produce a result only after the block was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared while idle");

endmodule

bind benchmark_fitness_evaluator_core bfe_checker u_bfe_checker (.*);
